// ----- sv/euler_rotate_offset_position_assert.svh -----
// assertion macros for the euler rotate offset position block
// needs a clock named i_clk and a reset named i_rst_n in the using module
`ifndef EULER_ROTATE_OFFSET_POSITION_ASSERT_SVH
`define EULER_ROTATE_OFFSET_POSITION_ASSERT_SVH

// check that holds outside reset
`define EROP_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("erop assertion failed");

// next-cycle check that holds outside reset
`define EROP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("erop assertion failed");

// next-cycle check that also covers reset
`define EROP_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("erop assertion failed");

`endif

// ----- sv/erop_pkg.sv -----
// shared types, constants and the cordic arctangent table
// no dependencies
`default_nettype none

package erop_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 24;

    localparam int POS_W  = 24;
    localparam int ANG_W  = 16;
    localparam int TRIG_W = 27;
    localparam int ZW     = 33;
    localparam int VEC_W  = 34;

    localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 27'sd10188013;

    typedef enum logic [2:0] {
        REG_BIAS_X   = 3'd0,
        REG_BIAS_Y   = 3'd1,
        REG_BIAS_Z   = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                    glove_present;
        logic signed [ANG_W-1:0] angle_x;
        logic signed [ANG_W-1:0] angle_y;
        logic signed [ANG_W-1:0] angle_z;
        logic signed [POS_W-1:0] center_x;
        logic signed [POS_W-1:0] center_y;
        logic signed [POS_W-1:0] center_z;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    saturated;
    } t_out;

    // sine and cosine of one angle
    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } t_trig;

    // atan(2^-i) in 2^-24 degree
    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 33'sd754974720;
            1:  v = 33'sd445687602;
            2:  v = 33'sd235489089;
            3:  v = 33'sd119537938;
            4:  v = 33'sd60000934;
            5:  v = 33'sd30029717;
            6:  v = 33'sd15018523;
            7:  v = 33'sd7509720;
            8:  v = 33'sd3754917;
            9:  v = 33'sd1877466;
            10: v = 33'sd938734;
            11: v = 33'sd469367;
            12: v = 33'sd234684;
            13: v = 33'sd117342;
            14: v = 33'sd58671;
            15: v = 33'sd29335;
            16: v = 33'sd14668;
            17: v = 33'sd7334;
            18: v = 33'sd3667;
            19: v = 33'sd1833;
            20: v = 33'sd917;
            21: v = 33'sd458;
            22: v = 33'sd229;
            23: v = 33'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- sv/erop_cordic.sv -----
// pipelined sine/cosine: angle fold stage then one register per cordic stage
// depends on erop_pkg
`default_nettype none

module erop_cordic #(
    parameter int CORDIC_STAGES = erop_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_en,
    input  wire logic signed [erop_pkg::ANG_W-1:0]  i_angle,
    output erop_pkg::t_trig                         o_trig
);

    localparam int N = CORDIC_STAGES;

    logic signed [16:0]                a_half;
    logic signed [16:0]                a_fold;
    logic                              a_flip;
    logic signed [13:0]                a_q;
    logic signed [erop_pkg::ZW-1:0]    z_init;

    logic signed [erop_pkg::TRIG_W-1:0] r_x [N+1];
    logic signed [erop_pkg::TRIG_W-1:0] r_y [N+1];
    logic signed [erop_pkg::ZW-1:0]     r_z [N+1];
    logic                               r_f [N+1];

    // fold to [-180,180) then to [-90,90]
    always_comb begin
        a_half = 17'(i_angle);
        if (a_half >= erop_pkg::HALF_TURN) begin
            a_half = a_half - erop_pkg::FULL_TURN;
        end else if (a_half < -erop_pkg::HALF_TURN) begin
            a_half = a_half + erop_pkg::FULL_TURN;
        end
        a_fold = a_half;
        a_flip = 1'b0;
        if (a_half > erop_pkg::QUARTER_TURN) begin
            a_fold = a_half - erop_pkg::HALF_TURN;
            a_flip = 1'b1;
        end else if (a_half < -erop_pkg::QUARTER_TURN) begin
            a_fold = a_half + erop_pkg::HALF_TURN;
            a_flip = 1'b1;
        end
        a_q    = a_fold[13:0];
        z_init = erop_pkg::ZW'(a_q) <<< 18;
    end

    // fold stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= erop_pkg::CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= z_init;
            r_f[0] <= a_flip;
        end
    end

    // rotation stages, one micro-rotation each
    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f[i+1] <= r_f[i];
                if (!r_z[i][erop_pkg::ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - erop_pkg::atan_q24(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + erop_pkg::atan_q24(i);
                end
            end
        end
    end

    // undo the half-turn fold
    assign o_trig.s = r_f[N] ? -r_y[N] : r_y[N];
    assign o_trig.c = r_f[N] ? -r_x[N] : r_x[N];

endmodule

`default_nettype wire

// ----- sv/erop_rotate.sv -----
// one axis rotation of a vector pair, multiply stage then round stage
// depends on erop_pkg
`default_nettype none

module erop_rotate (
    input  wire                                     i_clk,
    input  wire                                     i_en,
    input  erop_pkg::t_trig                         i_trig,
    input  wire logic signed [erop_pkg::VEC_W-1:0]  i_u,
    input  wire logic signed [erop_pkg::VEC_W-1:0]  i_v,
    input  wire logic signed [erop_pkg::VEC_W-1:0]  i_w,
    output logic signed [erop_pkg::VEC_W-1:0]       o_u,
    output logic signed [erop_pkg::VEC_W-1:0]       o_v,
    output logic signed [erop_pkg::VEC_W-1:0]       o_w
);

    localparam int PW = erop_pkg::TRIG_W + erop_pkg::VEC_W;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] r_cu, r_sv, r_cv, r_su;
    logic signed [erop_pkg::VEC_W-1:0] r_w1;
    logic signed [SW-1:0] n_su, n_sv;
    logic signed [SW-1:0] rnd;

    // products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cu <= PW'(i_trig.c) * PW'(i_u);
            r_sv <= PW'(i_trig.s) * PW'(i_v);
            r_cv <= PW'(i_trig.c) * PW'(i_v);
            r_su <= PW'(i_trig.s) * PW'(i_u);
            r_w1 <= i_w;
        end
    end

    // u' = c*u - s*v, v' = c*v + s*u, q24 trig fraction rounded off
    always_comb begin
        rnd  = SW'(64'sd8388608);
        n_su = SW'(r_cu) - SW'(r_sv) + rnd;
        n_sv = SW'(r_cv) + SW'(r_su) + rnd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_u <= n_su[24 +: erop_pkg::VEC_W];
            o_v <= n_sv[24 +: erop_pkg::VEC_W];
            o_w <= r_w1;
        end
    end

endmodule

`default_nettype wire

// ----- sv/euler_rotate_offset_position.sv -----
// Euler angle bias rotation, top level
//
// Input channel: i_in_valid / o_in_ready with payload i_in (erop_pkg::t_in).
// Output channel: o_out_valid / i_out_ready with payload o_out (erop_pkg::t_out).
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects bias_x..offset_z
// (0..5), other indexes are dropped; o_cfg_ready is always high. Write only while
// no item is in flight.
// One transfer is taken per cycle while the output is not stalled. The stages are
// one angle fold stage, one stage per cordic iteration, two per axis rotation
// (multiply, round) and one output stage with saturation.
// The whole pipeline moves as one: when the output holds a result that is not
// taken, every stage freezes and o_in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and the config registers to zero.
// Without glove_present the center passes through and saturated reads 0.
`default_nettype none

module euler_rotate_offset_position #(
    parameter int CORDIC_STAGES = erop_pkg::CORDIC_STAGES_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_in_valid,
    output logic                                    o_in_ready,
    input  erop_pkg::t_in                           i_in,
    output logic                                    o_out_valid,
    input  wire                                     i_out_ready,
    output erop_pkg::t_out                          o_out,
    input  wire                                     i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [2:0]                         i_cfg_index,
    input  wire logic [erop_pkg::POS_W-1:0]         i_cfg_data
);

    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = N + 7;
    localparam int PW    = erop_pkg::POS_W;
    localparam int VW    = erop_pkg::VEC_W;

    typedef struct packed {
        logic                 glove;
        logic signed [PW-1:0] cx;
        logic signed [PW-1:0] cy;
        logic signed [PW-1:0] cz;
    } t_side;

    logic en;
    logic signed [PW-1:0] r_bias_x, r_bias_y, r_bias_z;
    logic signed [PW-1:0] r_off_x, r_off_y, r_off_z;
    logic [DEPTH-1:0]     r_vld;
    t_side                r_side [DEPTH];
    erop_pkg::t_trig      trig_x, trig_y, trig_z;
    erop_pkg::t_trig      r_dly_y [2];
    erop_pkg::t_trig      r_dly_x [4];
    logic signed [VW-1:0] bx, by, bz;
    logic signed [VW-1:0] z_x, z_y, z_z;
    logic signed [VW-1:0] y_z, y_x, y_y;
    logic signed [VW-1:0] x_z, x_y, x_x;
    erop_pkg::t_out       n_out;
    logic                 r_out_glove;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_x <= '0;
            r_bias_y <= '0;
            r_bias_z <= '0;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_off_z  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                erop_pkg::REG_BIAS_X:   r_bias_x <= i_cfg_data;
                erop_pkg::REG_BIAS_Y:   r_bias_y <= i_cfg_data;
                erop_pkg::REG_BIAS_Z:   r_bias_z <= i_cfg_data;
                erop_pkg::REG_OFFSET_X: r_off_x  <= i_cfg_data;
                erop_pkg::REG_OFFSET_Y: r_off_y  <= i_cfg_data;
                erop_pkg::REG_OFFSET_Z: r_off_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and side payload travel alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{glove: i_in.glove_present, cx: i_in.center_x,
                           cy: i_in.center_y, cz: i_in.center_z};
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // sine and cosine of the three angles
    erop_cordic #(.CORDIC_STAGES(N)) u_cordic_x (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.angle_x), .o_trig(trig_x)
    );
    erop_cordic #(.CORDIC_STAGES(N)) u_cordic_y (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.angle_y), .o_trig(trig_y)
    );
    erop_cordic #(.CORDIC_STAGES(N)) u_cordic_z (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.angle_z), .o_trig(trig_z)
    );

    // hold y and x trig values until their rotation stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_y[0] <= trig_y;
            r_dly_y[1] <= r_dly_y[0];
            r_dly_x[0] <= trig_x;
            for (int k = 1; k < 4; k++) begin
                r_dly_x[k] <= r_dly_x[k-1];
            end
        end
    end

    // bias with 8 extra fraction bits
    assign bx = VW'(r_bias_x) <<< 8;
    assign by = VW'(r_bias_y) <<< 8;
    assign bz = VW'(r_bias_z) <<< 8;

    // rotate about z: (x, y)
    erop_rotate u_rot_z (
        .i_clk(i_clk), .i_en(en), .i_trig(trig_z),
        .i_u(bx), .i_v(by), .i_w(bz),
        .o_u(z_x), .o_v(z_y), .o_w(z_z)
    );

    // rotate about y: (z, x)
    erop_rotate u_rot_y (
        .i_clk(i_clk), .i_en(en), .i_trig(r_dly_y[1]),
        .i_u(z_z), .i_v(z_x), .i_w(z_y),
        .o_u(y_z), .o_v(y_x), .o_w(y_y)
    );

    // rotate about x: (y, z)
    erop_rotate u_rot_x (
        .i_clk(i_clk), .i_en(en), .i_trig(r_dly_x[3]),
        .i_u(y_y), .i_v(y_z), .i_w(y_x),
        .o_u(x_y), .o_v(x_z), .o_w(x_x)
    );

    // back to 1/16 unit, subtract from center, saturate
    always_comb begin
        logic signed [VW:0]   rx, ry, rz;
        logic signed [27:0]   dx, dy, dz;
        logic                 hit;
        t_side                sd;
        sd  = r_side[DEPTH-1];
        rx  = ((VW+1)'(x_x) + (VW+1)'(128)) >>> 8;
        ry  = ((VW+1)'(x_y) + (VW+1)'(128)) >>> 8;
        rz  = ((VW+1)'(x_z) + (VW+1)'(128)) >>> 8;
        dx  = 28'(sd.cx) - (28'(rx) + 28'(r_off_x));
        dy  = 28'(sd.cy) - (28'(ry) + 28'(r_off_y));
        dz  = 28'(sd.cz) - (28'(rz) + 28'(r_off_z));
        hit = 1'b0;
        n_out.pos_x = dx[PW-1:0];
        n_out.pos_y = dy[PW-1:0];
        n_out.pos_z = dz[PW-1:0];
        if (dx > 28'sd8388607) begin
            n_out.pos_x = 24'sh7fffff; hit = 1'b1;
        end else if (dx < -28'sd8388608) begin
            n_out.pos_x = 24'sh800000; hit = 1'b1;
        end
        if (dy > 28'sd8388607) begin
            n_out.pos_y = 24'sh7fffff; hit = 1'b1;
        end else if (dy < -28'sd8388608) begin
            n_out.pos_y = 24'sh800000; hit = 1'b1;
        end
        if (dz > 28'sd8388607) begin
            n_out.pos_z = 24'sh7fffff; hit = 1'b1;
        end else if (dz < -28'sd8388608) begin
            n_out.pos_z = 24'sh800000; hit = 1'b1;
        end
        n_out.saturated = hit;
        if (!sd.glove) begin
            n_out = '{pos_x: sd.cx, pos_y: sd.cy, pos_z: sd.cz, saturated: 1'b0};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out       <= n_out;
            r_out_glove <= r_side[DEPTH-1].glove;
        end
    end

`include "euler_rotate_offset_position_assert.svh"

    `EROP_ASSERT(a_sat_needs_glove, o_out_valid && o_out.saturated, r_out_glove)
    `EROP_ASSERT_NEXT(a_stall_freezes_line, !en, $stable(r_vld))
    `EROP_ASSERT_RST(a_reset_clears_out, !i_rst_n, !o_out_valid && (r_vld == '0))
    `EROP_ASSERT(a_ready_follows_out, !o_out_valid, o_in_ready)

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for euler_rotate_offset_position: directed table then random pose samples
// depends on erop_pkg and the euler_rotate_offset_position rtl
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int LATENCY = erop_pkg::CORDIC_STAGES_DEF + 8;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    erop_pkg::t_in  i_in;
    logic           o_out_valid;
    logic           i_out_ready;
    erop_pkg::t_out o_out;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [erop_pkg::POS_W-1:0] i_cfg_data;

    euler_rotate_offset_position i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor copy of the registers
    longint bias_q[3];
    longint offs_q[3];

    erop_pkg::t_out pose_q[$];
    int     n_fail;
    int     n_items;
    int     n_results;
    bit     rx_hold;

    // one directed row: input and, where obvious, the typed-in result
    typedef struct {
        erop_pkg::t_in  item;
        bit             has_exp;
        erop_pkg::t_out exp;
    } t_row;

    function automatic longint fdiv(longint v, int s);
        return v >>> s;
    endfunction

    // folded cordic sine and cosine, Q24
    function automatic void angle_trig(input logic signed [erop_pkg::ANG_W-1:0] ang,
                                       output longint s, output longint c);
        longint r, z, x, y, nx;
        bit flip;
        r = ang;
        x = 10188013;
        y = 0;
        flip = 0;
        if (r >= 11520) r -= 23040;
        if (r < -11520) r += 23040;
        if (r > 5760) begin
            r -= 11520;
            flip = 1;
        end else if (r < -5760) begin
            r += 11520;
            flip = 1;
        end
        z = r * 262144;
        for (int i = 0; i < erop_pkg::CORDIC_STAGES_DEF; i++) begin
            if (z >= 0) begin
                nx = x - fdiv(y, i);
                y = y + fdiv(x, i);
                z -= longint'(erop_pkg::atan_q24(i));
            end else begin
                nx = x + fdiv(y, i);
                y = y - fdiv(x, i);
                z += longint'(erop_pkg::atan_q24(i));
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint rot_mix(longint c, longint u, longint s, longint v);
        return fdiv(c * u - s * v + 8388608, 24);
    endfunction

    function automatic longint clamp24(longint v, ref bit hit);
        if (v > 8388607) begin
            hit = 1;
            return 8388607;
        end
        if (v < -8388608) begin
            hit = 1;
            return -8388608;
        end
        return v;
    endfunction

    function automatic erop_pkg::t_out hand_position(erop_pkg::t_in d);
        erop_pkg::t_out r;
        longint sx, cx, sy, cy, sz, cz, x, y, z, t, px, py, pz;
        bit hit;
        hit = 0;
        px = d.center_x;
        py = d.center_y;
        pz = d.center_z;
        if (d.glove_present) begin
            angle_trig(d.angle_x, sx, cx);
            angle_trig(d.angle_y, sy, cy);
            angle_trig(d.angle_z, sz, cz);
            x = bias_q[0] * 256;
            y = bias_q[1] * 256;
            z = bias_q[2] * 256;
            t = rot_mix(cz, x, sz, y);
            y = rot_mix(cz, y, -sz, x);
            x = t;
            t = rot_mix(cy, x, -sy, z);
            z = rot_mix(cy, z, sy, x);
            x = t;
            t = rot_mix(cx, y, sx, z);
            z = rot_mix(cx, z, -sx, y);
            y = t;
            x = fdiv(x + 128, 8);
            y = fdiv(y + 128, 8);
            z = fdiv(z + 128, 8);
            px = clamp24(px - (x + offs_q[0]), hit);
            py = clamp24(py - (y + offs_q[1]), hit);
            pz = clamp24(pz - (z + offs_q[2]), hit);
        end
        r.pos_x = px[23:0];
        r.pos_y = py[23:0];
        r.pos_z = pz[23:0];
        r.saturated = hit;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin
        erop_pkg::t_out e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                n_fail++;
            end else begin
                e = pose_q.pop_front();
                if (o_out.pos_x !== e.pos_x)
                    $display("%0t: pos_x exp %h got %h", $time, e.pos_x, o_out.pos_x);
                if (o_out.pos_y !== e.pos_y)
                    $display("%0t: pos_y exp %h got %h", $time, e.pos_y, o_out.pos_y);
                if (o_out.pos_z !== e.pos_z)
                    $display("%0t: pos_z exp %h got %h", $time, e.pos_z, o_out.pos_z);
                if (o_out.saturated !== e.saturated)
                    $display("%0t: saturated exp %b got %b", $time, e.saturated,
                             o_out.saturated);
                if (o_out !== e) n_fail++;
            end
        end
    end

    // receiver stalls, with a long hold when asked
    initial begin
        int k;
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_out_ready <= 0;
                for (k = 0; k < 200; k++) @(negedge i_clk);
                rx_hold = 0;
            end else if ($urandom_range(0, 9) < 2) begin
                i_out_ready <= 0;
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
                repeat (k - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end
        end
    end

    task automatic cfg_write(erop_pkg::t_reg_idx idx, longint val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[23:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < erop_pkg::REG_OFFSET_X) bias_q[idx] = longint'($signed(val[23:0]));
        else offs_q[idx - erop_pkg::REG_OFFSET_X] = longint'($signed(val[23:0]));
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    // drops the input valid and waits until the pipeline has drained
    task automatic drain();
        i_in_valid <= 0;
        while (pose_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // one transfer on the input channel, with an optional random gap first
    task automatic send_pose(erop_pkg::t_in d, bit gaps);
        int g;
        if (gaps && $urandom_range(0, 4) == 0) begin
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 3);
            i_in_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_in <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pose_q.push_back(hand_position(d));
        n_items++;
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'(-23040 + $urandom_range(0, 46080));
            2: return 16'($urandom_range(0, 8) * 2880 - 11520);
            default: return 16'(int'($urandom_range(0, 2880)) - 1440);
        endcase
    endfunction

    function automatic logic [23:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(0, 20)) - 10 + 8388607);
            default: return 24'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic erop_pkg::t_in rand_pose();
        erop_pkg::t_in d;
        d.glove_present = ($urandom_range(0, 7) != 0);
        d.angle_x = rand_angle();
        d.angle_y = rand_angle();
        d.angle_z = rand_angle();
        d.center_x = rand_pos();
        d.center_y = rand_pos();
        d.center_z = rand_pos();
        return d;
    endfunction

    // main stimulus
    initial begin
        t_row rows[$];
        t_row rw;
        longint cfg_v;
        n_fail = 0;
        n_items = 0;
        n_results = 0;
        rx_hold = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < 3; i++) begin
            bias_q[i] = 0;
            offs_q[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed rows under reset registers: result is the center itself
        rw.has_exp = 1;
        rw.item = '{1'b0, 16'sh7fff, 16'sh8000, 16'sd11520, 24'sh7fffff, 24'sh800000, 24'sd0};
        rw.exp = '{24'sh7fffff, 24'sh800000, 24'sd0, 1'b0};
        rows.push_back(rw);
        rw.item = '{1'b1, 16'sd23040, -16'sd23040, 16'sd0, 24'sh800000, 24'sd1, 24'sh7fffff};
        rw.exp = '{24'sh800000, 24'sd1, 24'sh7fffff, 1'b0};
        rows.push_back(rw);
        foreach (rows[i]) begin
            send_pose(rows[i].item, 0);
            if (rows[i].has_exp) pose_q[$] = rows[i].exp;
        end
        drain();

        // nonzero bias and offset, then angle extremes and special angles
        cfg_write(erop_pkg::REG_BIAS_X, 1600);
        cfg_write(erop_pkg::REG_BIAS_Y, -3200);
        cfg_write(erop_pkg::REG_BIAS_Z, 800);
        cfg_write(erop_pkg::REG_OFFSET_X, 16);
        cfg_write(erop_pkg::REG_OFFSET_Y, -48);
        cfg_write(erop_pkg::REG_OFFSET_Z, 100);
        rows.delete();
        rw.has_exp = 0;
        for (int i = 0; i < 11; i++) begin
            logic signed [15:0] a;
            case (i)
                0: a = 0;  1: a = 11520;  2: a = -11520;  3: a = 5760;
                4: a = -5760;  5: a = 5761;  6: a = 23040;  7: a = 16'sh7fff;
                8: a = 16'sh8000;  9: a = 2880;  default: a = -1;
            endcase
            rw.item = '{1'b1, a, 16'(-a), 16'(a + 960), 24'sd1000, -24'sd1000, 24'sd5};
            rows.push_back(rw);
        end
        // saturation in both directions with the offset pushing over
        cfg_write(erop_pkg::REG_OFFSET_X, -8388608);
        cfg_write(erop_pkg::REG_OFFSET_Y, 8388607);
        foreach (rows[i]) send_pose(rows[i].item, 0);
        send_pose('{1'b1, 16'sd0, 16'sd0, 16'sd0, 24'sh7fffff, 24'sh800000, 24'sd0}, 0);
        drain();

        // random phases over several register settings, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 6; r++) begin
                case (ph)
                    0: cfg_v = 0;
                    1: cfg_v = (r % 2) ? 8388607 : -8388608;
                    2: cfg_v = longint'($signed(24'($urandom)));
                    default: cfg_v = int'($urandom_range(0, 64000)) - 32000;
                endcase
                cfg_write(erop_pkg::t_reg_idx'(r), cfg_v);
            end
            for (int n = 0; n < 170; n++) begin
                if (ph == 2 && n == 20) rx_hold = 1;
                send_pose(rand_pose(), !(ph == 3 && n < 60));
            end
            // sender waits for every result
            drain();
        end
        drain();
        $display("covered %0d pose samples, %0d results, six register settings", n_items,
                 n_results);
        if (n_fail == 0 && pose_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- euler_rotate_offset_position.f -----
+incdir+sv
sv/erop_pkg.sv
sv/erop_cordic.sv
sv/erop_rotate.sv
sv/euler_rotate_offset_position.sv
tb/sv/tb_top.sv
